### rtl/crcfr_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and the CRC-16 byte step for the framed request engine.
package crcfr_pkg;

    localparam logic [2:0] CMD_START = 3'd0;
    localparam logic [2:0] CMD_PAYLOAD = 3'd1;
    localparam logic [2:0] CMD_TICK = 3'd2;
    localparam logic [2:0] CMD_PULL = 3'd3;
    localparam logic [2:0] CMD_RX_BYTE = 3'd4;
    localparam logic [2:0] CMD_FRAME_END = 3'd5;
    localparam logic [2:0] CMD_READ = 3'd6;

    localparam logic CFG_IDX_MAX_TRIES = 1'b0;
    localparam int ADDR_W = 3;

    localparam logic [2:0] TXK_NONE = 3'd0;
    localparam logic [2:0] TXK_HDR = 3'd1;
    localparam logic [2:0] TXK_PAY = 3'd2;
    localparam logic [2:0] TXK_CRC_LO = 3'd3;
    localparam logic [2:0] TXK_CRC_HI = 3'd4;

    localparam int HEADER_BYTES = 23;
    localparam int MIN_REPLY = 3;
    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [3:0] MAX_TRIES_RST = 4'd3;
    localparam logic [3:0] ATT_SAT = 4'd15;
    localparam int MAX_PAYLOAD_DEF = 256;
    localparam int REPLY_DEPTH_DEF = 256;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [31:0] uid_first;
        logic [31:0] uid_second;
        logic [31:0] uid_third;
        logic [15:0] request_code;
        logic [31:0] mem_address;
        logic [8:0]  payload_length;
        logic [15:0] timeout_ticks;
        logic [7:0]  data_byte;
        logic [7:0]  response_index;
    } t_item;

    typedef struct packed {
        logic start;
        logic pay;
        logic tick;
        logic pull;
        logic rxb;
        logic fend;
        logic rd;
    } t_cls;

    typedef struct packed {
        t_cls  cls;
        t_item it;
    } t_word;

    typedef struct packed {
        logic [2:0] txk;
        logic [7:0] hdr_byte;
        logic       crc_rst;
        logic       rd_hit;
        logic       busy;
        logic       failed;
        logic [3:0] retry;
        logic [8:0] reply_len;
        logic       bad;
    } t_emit;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

### rtl/crc_framed_request_retry_engine_core.sv
`timescale 1ns / 1ps
// Top level of the CRC-framed request master with timeout and retry.
//
// Usage: every input word carries a command (start, payload byte, tick,
// transmit pull, received byte, frame end, read reply) and its fields;
// every accepted word yields exactly one output word with the tx byte,
// status flags, retry count, reply length and the read reply byte.
// Both channels use valid/ready; a word moves when both are high.
// Path: an accepted word enters the queue, is executed with its store
// read in the execute stage, lands in the output register of the emit
// stage, and shows at o_valid.
// Throughput: one word per cycle while i_ready is high; the execute stage
// touches each store through one write and one registered read per cycle.
// A two-word queue decouples input from execution; when the receiver
// holds i_ready low the output word holds, the pipeline fills, and
// o_ready drops once the queue is full. No word is lost.
// Reset (synchronous, i_rst_n low) clears all control state, sets
// max_tries to 3 and the CRC accumulators to all ones. The payload and
// reply stores are not cleared; no clearing pass is needed.
// Configuration: APB register 0 (max_tries, 4 bits) at byte address 0.
module crc_framed_request_retry_engine_core #(
    parameter int MAX_PAYLOAD = crcfr_pkg::MAX_PAYLOAD_DEF,
    parameter int REPLY_DEPTH = crcfr_pkg::REPLY_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input word channel
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_cmd,
    input  logic [31:0] i_uid_first,
    input  logic [31:0] i_uid_second,
    input  logic [31:0] i_uid_third,
    input  logic [15:0] i_request_code,
    input  logic [31:0] i_mem_address,
    input  logic [8:0]  i_payload_length,
    input  logic [15:0] i_timeout_ticks,
    input  logic [7:0]  i_data_byte,
    input  logic [7:0]  i_response_index,
    // result word channel
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_tx_valid,
    output logic [7:0]  o_tx_byte,
    output logic        o_tx_last,
    output logic        o_busy_res,
    output logic        o_failed,
    output logic [3:0]  o_retry_count,
    output logic [8:0]  o_reply_length,
    output logic [7:0]  o_reply_byte,
    output logic        o_bad_frame,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [crcfr_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [3:0] r_max_tries;
    logic cfg_sel;

    crcfr_pkg::t_item in_item;
    crcfr_pkg::t_word head;
    crcfr_pkg::t_emit b_word;
    logic head_v, pop, b_v, b_pop;
    logic [7:0] b_rd;

    // Register index is the word address; only index 0 exists.
    assign cfg_sel = (paddr[crcfr_pkg::ADDR_W-1] == crcfr_pkg::CFG_IDX_MAX_TRIES);
    assign pready = 1'b1;
    assign prdata = cfg_sel ? {28'd0, r_max_tries} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_tries <= crcfr_pkg::MAX_TRIES_RST;
        end else if (psel && penable && pwrite && cfg_sel) begin
            r_max_tries <= pwdata[3:0];
        end
    end

    // Gather the input fields into one word for the queue.
    assign in_item = '{cmd: i_cmd, uid_first: i_uid_first, uid_second: i_uid_second,
                       uid_third: i_uid_third, request_code: i_request_code,
                       mem_address: i_mem_address, payload_length: i_payload_length,
                       timeout_ticks: i_timeout_ticks, data_byte: i_data_byte,
                       response_index: i_response_index};

    // Front: queue and decode.
    crcfr_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_item       (in_item),
        .o_head_valid (head_v),
        .o_head       (head),
        .i_pop        (pop)
    );

    // Back, first half: advance transaction state and issue store reads.
    crcfr_exec #(
        .MAX_PAYLOAD (MAX_PAYLOAD),
        .REPLY_DEPTH (REPLY_DEPTH)
    ) u_exec (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_max_tries  (r_max_tries),
        .i_head_valid (head_v),
        .i_head       (head),
        .o_pop        (pop),
        .o_b_valid    (b_v),
        .o_b          (b_word),
        .o_b_rd       (b_rd),
        .i_b_pop      (b_pop)
    );

    // Back, second half: fold frame CRC, select byte, hold the result word.
    crcfr_emit u_emit (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_b_valid      (b_v),
        .i_b            (b_word),
        .i_b_rd         (b_rd),
        .o_b_pop        (b_pop),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_tx_valid     (o_tx_valid),
        .o_tx_byte      (o_tx_byte),
        .o_tx_last      (o_tx_last),
        .o_busy_res     (o_busy_res),
        .o_failed       (o_failed),
        .o_retry_count  (o_retry_count),
        .o_reply_length (o_reply_length),
        .o_reply_byte   (o_reply_byte),
        .o_bad_frame    (o_bad_frame)
    );

endmodule

### rtl/crcfr_front.sv
`timescale 1ns / 1ps
// Front end: two-entry word queue that decodes each command.
module crcfr_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  crcfr_pkg::t_item   i_item,
    output logic               o_head_valid,
    output crcfr_pkg::t_word   o_head,
    input  logic               i_pop
);

    crcfr_pkg::t_word r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    crcfr_pkg::t_cls cls;
    logic push, pop;

    always_comb begin
        cls = '0;
        case (i_item.cmd)
            crcfr_pkg::CMD_START:     cls.start = 1'b1;
            crcfr_pkg::CMD_PAYLOAD:   cls.pay = 1'b1;
            crcfr_pkg::CMD_TICK:      cls.tick = 1'b1;
            crcfr_pkg::CMD_PULL:      cls.pull = 1'b1;
            crcfr_pkg::CMD_RX_BYTE:   cls.rxb = 1'b1;
            crcfr_pkg::CMD_FRAME_END: cls.fend = 1'b1;
            crcfr_pkg::CMD_READ:      cls.rd = 1'b1;
            default:                  cls = '0;
        endcase
    end

    assign o_ready = (r_cnt != 2'd2);
    assign push = i_valid && o_ready;
    assign o_head_valid = (r_cnt != 2'd0);
    assign pop = i_pop && o_head_valid;
    assign o_head = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= '{cls: cls, it: i_item};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

### rtl/crcfr_exec.sv
`timescale 1ns / 1ps
// Execute stage: transaction state, payload and reply stores, staged result.
module crcfr_exec #(
    parameter int MAX_PAYLOAD = crcfr_pkg::MAX_PAYLOAD_DEF,
    parameter int REPLY_DEPTH = crcfr_pkg::REPLY_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [3:0]         i_max_tries,
    input  logic               i_head_valid,
    input  crcfr_pkg::t_word   i_head,
    output logic               o_pop,
    output logic               o_b_valid,
    output crcfr_pkg::t_emit   o_b,
    output logic [7:0]         o_b_rd,
    input  logic               i_b_pop
);

    localparam int PL_W = $clog2(MAX_PAYLOAD + 1);
    localparam int PA_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int TP_W = $clog2(MAX_PAYLOAD + crcfr_pkg::HEADER_BYTES + 2);
    localparam int RC_W = $clog2(REPLY_DEPTH + 1);
    localparam int RA_W = $clog2(REPLY_DEPTH);
    localparam int LC_W = (PL_W > 9) ? PL_W : 9;
    localparam int IX_W = (RC_W > 8) ? RC_W : 8;

    logic [7:0] r_pmem [MAX_PAYLOAD];
    logic [7:0] r_rmem [REPLY_DEPTH];

    logic [31:0] r_id0, r_id1, r_id2, r_addr;
    logic [15:0] r_code;
    logic [PL_W-1:0] r_hlen, r_fill;
    logic [TP_W-1:0] r_tpos;
    logic r_tpend;
    logic [15:0] r_wait, r_sto;
    logic [3:0] r_att;
    logic r_busy, r_err;
    logic [RC_W-1:0] r_rxc, r_rcnt;
    logic [15:0] r_rxcrc, r_tail;

    logic [31:0] n_id0, n_id1, n_id2, n_addr;
    logic [15:0] n_code;
    logic [PL_W-1:0] n_hlen, n_fill;
    logic [TP_W-1:0] n_tpos;
    logic n_tpend;
    logic [15:0] n_wait, n_sto;
    logic [3:0] n_att;
    logic n_busy, n_err;
    logic [RC_W-1:0] n_rxc, n_rcnt;
    logic [15:0] n_rxcrc, n_tail;

    logic r_bv;
    crcfr_pkg::t_emit r_b;
    logic [7:0] r_prd, r_rrd;

    crcfr_pkg::t_emit em;
    logic go, b_ready, listening;
    logic pw_en, rw_en, pr_en, rr_en;
    logic [PA_W-1:0] pr_addr;
    logic [RA_W-1:0] rr_addr;
    logic [LC_W-1:0] len_w;
    logic [TP_W-1:0] body, k;
    logic [15:0] w1;
    logic [3:0] att1;
    logic [31:0] hlen32;
    logic [IX_W-1:0] idx_w;
    crcfr_pkg::t_cls c;
    crcfr_pkg::t_item it;

    assign b_ready = !r_bv || i_b_pop;
    assign go = i_head_valid && b_ready;
    assign o_pop = go;
    assign c = i_head.cls;
    assign it = i_head.it;
    assign listening = r_busy && (r_wait != 16'd0);
    assign att1 = (r_att == crcfr_pkg::ATT_SAT) ? r_att : r_att + 4'd1;
    assign hlen32 = 32'(r_hlen);
    assign body = TP_W'(crcfr_pkg::HEADER_BYTES) + TP_W'(r_hlen);
    assign k = r_tpos - TP_W'(crcfr_pkg::HEADER_BYTES);
    assign len_w = LC_W'(it.payload_length);
    assign idx_w = IX_W'(it.response_index);
    assign w1 = r_wait - 16'd1;

    always_comb begin
        n_id0 = r_id0; n_id1 = r_id1; n_id2 = r_id2; n_addr = r_addr;
        n_code = r_code; n_hlen = r_hlen; n_fill = r_fill;
        n_tpos = r_tpos; n_tpend = r_tpend; n_wait = r_wait; n_sto = r_sto;
        n_att = r_att; n_busy = r_busy; n_err = r_err;
        n_rxc = r_rxc; n_rcnt = r_rcnt; n_rxcrc = r_rxcrc; n_tail = r_tail;
        em = '0;
        pw_en = 1'b0; rw_en = 1'b0; pr_en = 1'b0; rr_en = 1'b0;
        pr_addr = k[PA_W-1:0];
        rr_addr = idx_w[RA_W-1:0];

        if (c.start) begin
            n_id0 = it.uid_first; n_id1 = it.uid_second; n_id2 = it.uid_third;
            n_code = it.request_code; n_addr = it.mem_address;
            n_hlen = (len_w > LC_W'(MAX_PAYLOAD)) ? PL_W'(MAX_PAYLOAD) : PL_W'(len_w);
            n_fill = '0;
            n_sto = it.timeout_ticks; n_wait = it.timeout_ticks;
            n_att = 4'd0; n_busy = 1'b1; n_err = 1'b0;
            n_tpos = '0; n_tpend = 1'b1; em.crc_rst = 1'b1;
            n_rxc = '0; n_rxcrc = crcfr_pkg::CRC_INIT; n_tail = 16'd0;
        end else if (c.pay) begin
            if (r_fill < r_hlen) begin
                pw_en = 1'b1;
                n_fill = r_fill + PL_W'(1);
            end
        end else if (c.tick) begin
            if (r_wait != 16'd0) begin
                n_wait = w1;
                if (w1 == 16'd0) begin
                    n_att = att1;
                    if (att1 >= i_max_tries) begin
                        n_err = 1'b1; n_busy = 1'b0;
                    end else begin
                        n_wait = r_sto;
                        n_tpos = '0; n_tpend = 1'b1; em.crc_rst = 1'b1;
                    end
                end
            end
        end else if (c.pull) begin
            if (r_tpend) begin
                if (r_tpos < TP_W'(crcfr_pkg::HEADER_BYTES)) begin
                    em.txk = crcfr_pkg::TXK_HDR;
                    case (r_tpos[4:0])
                        5'd1:  em.hdr_byte = r_id0[7:0];
                        5'd2:  em.hdr_byte = r_id0[15:8];
                        5'd3:  em.hdr_byte = r_id0[23:16];
                        5'd4:  em.hdr_byte = r_id0[31:24];
                        5'd5:  em.hdr_byte = r_id1[7:0];
                        5'd6:  em.hdr_byte = r_id1[15:8];
                        5'd7:  em.hdr_byte = r_id1[23:16];
                        5'd8:  em.hdr_byte = r_id1[31:24];
                        5'd9:  em.hdr_byte = r_id2[7:0];
                        5'd10: em.hdr_byte = r_id2[15:8];
                        5'd11: em.hdr_byte = r_id2[23:16];
                        5'd12: em.hdr_byte = r_id2[31:24];
                        5'd13: em.hdr_byte = r_code[7:0];
                        5'd14: em.hdr_byte = r_code[15:8];
                        5'd15: em.hdr_byte = r_addr[7:0];
                        5'd16: em.hdr_byte = r_addr[15:8];
                        5'd17: em.hdr_byte = r_addr[23:16];
                        5'd18: em.hdr_byte = r_addr[31:24];
                        5'd19: em.hdr_byte = hlen32[7:0];
                        5'd20: em.hdr_byte = hlen32[15:8];
                        5'd21: em.hdr_byte = hlen32[23:16];
                        5'd22: em.hdr_byte = hlen32[31:24];
                        default: em.hdr_byte = 8'd0;
                    endcase
                end else if (r_tpos < body) begin
                    em.txk = crcfr_pkg::TXK_PAY;
                    pr_en = 1'b1;
                end else if (r_tpos == body) begin
                    em.txk = crcfr_pkg::TXK_CRC_LO;
                end else begin
                    em.txk = crcfr_pkg::TXK_CRC_HI;
                end
                if (em.txk == crcfr_pkg::TXK_CRC_HI) begin
                    n_tpend = 1'b0; n_tpos = '0;
                end else begin
                    n_tpos = r_tpos + TP_W'(1);
                end
            end
        end else if (c.rxb) begin
            if (listening && (r_rxc < RC_W'(REPLY_DEPTH))) begin
                if (r_rxc >= RC_W'(2)) n_rxcrc = crcfr_pkg::crc_byte(r_rxcrc, r_tail[7:0]);
                n_tail = {it.data_byte, r_tail[15:8]};
                rw_en = 1'b1;
                n_rxc = r_rxc + RC_W'(1);
            end
        end else if (c.fend) begin
            if (listening && (r_rxc != '0)) begin
                if ((r_rxc < RC_W'(crcfr_pkg::MIN_REPLY)) || (r_rxcrc != r_tail)) begin
                    em.bad = 1'b1;
                    n_att = att1;
                    if (att1 >= i_max_tries) begin
                        n_att = 4'd0; n_err = 1'b1; n_busy = 1'b0; n_wait = 16'd0;
                    end else begin
                        n_wait = r_sto;
                        n_tpos = '0; n_tpend = 1'b1; em.crc_rst = 1'b1;
                    end
                end else begin
                    n_rcnt = r_rxc; n_wait = 16'd0; n_busy = 1'b0;
                    n_err = 1'b0; n_att = 4'd0;
                end
            end
            n_rxc = '0; n_rxcrc = crcfr_pkg::CRC_INIT; n_tail = 16'd0;
        end else if (c.rd) begin
            if ((idx_w < IX_W'(r_rcnt)) && (idx_w < IX_W'(REPLY_DEPTH))) begin
                em.rd_hit = 1'b1;
                rr_en = 1'b1;
            end
        end

        em.busy = n_busy;
        em.failed = n_err;
        em.retry = n_att;
        em.reply_len = 9'(n_rcnt);
    end

    always_ff @(posedge i_clk) begin
        if (go && pw_en) r_pmem[r_fill[PA_W-1:0]] <= it.data_byte;
        if (go && pr_en) r_prd <= r_pmem[pr_addr];
    end

    always_ff @(posedge i_clk) begin
        if (go && rw_en) r_rmem[r_rxc[RA_W-1:0]] <= it.data_byte;
        if (go && rr_en) r_rrd <= r_rmem[rr_addr];
    end

    always_ff @(posedge i_clk) begin
        if (go) r_b <= em;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_id0 <= '0; r_id1 <= '0; r_id2 <= '0; r_addr <= '0; r_code <= '0;
            r_hlen <= '0; r_fill <= '0; r_tpos <= '0; r_tpend <= 1'b0;
            r_wait <= '0; r_sto <= '0; r_att <= '0; r_busy <= 1'b0; r_err <= 1'b0;
            r_rxc <= '0; r_rcnt <= '0; r_rxcrc <= crcfr_pkg::CRC_INIT; r_tail <= '0;
            r_bv <= 1'b0;
        end else begin
            if (go) begin
                r_id0 <= n_id0; r_id1 <= n_id1; r_id2 <= n_id2; r_addr <= n_addr;
                r_code <= n_code; r_hlen <= n_hlen; r_fill <= n_fill;
                r_tpos <= n_tpos; r_tpend <= n_tpend; r_wait <= n_wait; r_sto <= n_sto;
                r_att <= n_att; r_busy <= n_busy; r_err <= n_err;
                r_rxc <= n_rxc; r_rcnt <= n_rcnt; r_rxcrc <= n_rxcrc; r_tail <= n_tail;
            end
            if (b_ready) r_bv <= i_head_valid;
        end
    end

    assign o_b_valid = r_bv;
    assign o_b = r_b;
    assign o_b_rd = (r_b.txk == crcfr_pkg::TXK_PAY) ? r_prd : r_rrd;

endmodule

### rtl/crcfr_emit.sv
`timescale 1ns / 1ps
// Emit stage: frame CRC, byte selection and the output word register.
module crcfr_emit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_b_valid,
    input  crcfr_pkg::t_emit   i_b,
    input  logic [7:0]         i_b_rd,
    output logic               o_b_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_tx_valid,
    output logic [7:0]         o_tx_byte,
    output logic               o_tx_last,
    output logic               o_busy_res,
    output logic               o_failed,
    output logic [3:0]         o_retry_count,
    output logic [8:0]         o_reply_length,
    output logic [7:0]         o_reply_byte,
    output logic               o_bad_frame
);

    logic r_ov;
    logic [15:0] r_crc, n_crc;
    logic [7:0] tx_b;
    logic adv;

    assign adv = !r_ov || i_ready;
    assign o_b_pop = adv;
    assign o_valid = r_ov;

    always_comb begin
        case (i_b.txk)
            crcfr_pkg::TXK_HDR:    tx_b = i_b.hdr_byte;
            crcfr_pkg::TXK_PAY:    tx_b = i_b_rd;
            crcfr_pkg::TXK_CRC_LO: tx_b = r_crc[7:0];
            crcfr_pkg::TXK_CRC_HI: tx_b = r_crc[15:8];
            default:               tx_b = 8'd0;
        endcase
        if (i_b.crc_rst) begin
            n_crc = crcfr_pkg::CRC_INIT;
        end else if ((i_b.txk == crcfr_pkg::TXK_HDR) || (i_b.txk == crcfr_pkg::TXK_PAY)) begin
            n_crc = crcfr_pkg::crc_byte(r_crc, tx_b);
        end else begin
            n_crc = r_crc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && i_b_valid) begin
            o_tx_valid <= (i_b.txk != crcfr_pkg::TXK_NONE);
            o_tx_byte <= tx_b;
            o_tx_last <= (i_b.txk == crcfr_pkg::TXK_CRC_HI);
            o_busy_res <= i_b.busy;
            o_failed <= i_b.failed;
            o_retry_count <= i_b.retry;
            o_reply_length <= i_b.reply_len;
            o_reply_byte <= i_b.rd_hit ? i_b_rd : 8'd0;
            o_bad_frame <= i_b.bad;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_crc <= crcfr_pkg::CRC_INIT;
        end else begin
            if (adv) r_ov <= i_b_valid;
            if (adv && i_b_valid) r_crc <= n_crc;
        end
    end

endmodule
